// ----- sv/scaled_texture_column_blit_macros.svh -----
// Assertion macros shared by the scaled texture column blitter RTL.
`ifndef SCALED_TEXTURE_COLUMN_BLIT_MACROS_SVH
`define SCALED_TEXTURE_COLUMN_BLIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STCB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stcb check failed");

// The consequent must hold in the cycle after the antecedent.
`define STCB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stcb check failed");

`endif

// ----- sv/stcb_pkg.sv -----
// Package with the item codes, register indexes and constants of the blitter.
`default_nettype none

package stcb_pkg;

   typedef enum logic [1:0] {
      ACT_CM_LOAD = 2'd0,
      ACT_BL_LOAD = 2'd1,
      ACT_START   = 2'd2,
      ACT_PIXEL   = 2'd3
   } action_type;

   typedef logic [3:0] csr_index_type;

   localparam csr_index_type CSR_COL_START      = 4'd0;
   localparam csr_index_type CSR_ROW_START      = 4'd1;
   localparam csr_index_type CSR_COL_STEP       = 4'd2;
   localparam csr_index_type CSR_ROW_STEP       = 4'd3;
   localparam csr_index_type CSR_SPAN_COLS      = 4'd4;
   localparam csr_index_type CSR_SPAN_ROWS      = 4'd5;
   localparam csr_index_type CSR_TEXTURE_HEIGHT = 4'd6;
   localparam csr_index_type CSR_MODE           = 4'd7;

   localparam int CSR_DATA_W = 26;
   localparam int ADDR_W     = 20;
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 11;

   localparam logic [25:0] COL_STEP_RESET = 26'h001_0000;
   localparam logic [24:0] ROW_STEP_RESET = 25'h001_0000;

endpackage

`default_nettype wire

// ----- sv/stcb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module stcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/scaled_texture_column_blit.sv -----
// Top level of the scaled texture column blitter with colormap and translucency.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_stall  action, table index/value, texel, background
//   rsp      out        rsp_valid/rsp_stall  pixel, destination, fetch address, flags
//   csr      in         csr_valid/csr_ready  register index and write data
//
// One item is accepted per cycle while req_stall is low. A result is registered in
// stage 1, stage 2 and the output register, behind the colormap RAM read, then the
// blend RAM read, with the fetch address multiply and add running alongside them.
// Reset is synchronous and clears the walk state and all pipeline valid flags.
// Each stage holds while the stage after it is full and stalled, so bubbles drain.
`default_nettype none

`include "scaled_texture_column_blit_macros.svh"

module scaled_texture_column_blit #(
   parameter int MAX_SPAN  = 1024,
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_table_index,
   input  wire logic [7:0]  req_table_value,
   input  wire logic [7:0]  req_texel,
   input  wire logic [7:0]  req_background,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_pixel,
   output logic             rsp_pixel_valid,
   output logic [9:0]       rsp_dest_col,
   output logic [9:0]       rsp_dest_row,
   output logic [19:0]      rsp_fetch_address,
   output logic             rsp_fetch_valid,
   output logic             rsp_last,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [25:0] csr_data
);

   localparam logic [12:0] MaxSpan13 = 13'(MAX_SPAN);

   function automatic logic [10:0] clamp_span(input logic [10:0] s);
      logic [10:0] r;
      if (s == 11'd0) begin
         r = 11'd1;
      end else if ({2'b00, s} > MaxSpan13) begin
         r = MaxSpan13[10:0];
      end else begin
         r = s;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [25:0] col_start_ff;
   logic [25:0] row_start_ff;
   logic [25:0] col_step_ff;
   logic [24:0] row_step_ff;
   logic [10:0] span_cols_ff;
   logic [10:0] span_rows_ff;
   logic [10:0] tex_height_ff;
   logic [1:0]  mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_start_ff  <= 26'd0;
         row_start_ff  <= 26'd0;
         col_step_ff   <= stcb_pkg::COL_STEP_RESET;
         row_step_ff   <= stcb_pkg::ROW_STEP_RESET;
         span_cols_ff  <= 11'd1;
         span_rows_ff  <= 11'd1;
         tex_height_ff <= 11'd1;
         mode_ff       <= 2'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            stcb_pkg::CSR_COL_START:      col_start_ff  <= csr_data;
            stcb_pkg::CSR_ROW_START:      row_start_ff  <= csr_data;
            stcb_pkg::CSR_COL_STEP:       col_step_ff   <= csr_data;
            stcb_pkg::CSR_ROW_STEP:       row_step_ff   <= csr_data[24:0];
            stcb_pkg::CSR_SPAN_COLS:      span_cols_ff  <= csr_data[10:0];
            stcb_pkg::CSR_SPAN_ROWS:      span_rows_ff  <= csr_data[10:0];
            stcb_pkg::CSR_TEXTURE_HEIGHT: tex_height_ff <= csr_data[10:0];
            stcb_pkg::CSR_MODE:           mode_ff       <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control.
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load, en2, en1, accept;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en2       = !s2_vld_ff || out_load;
   assign en1       = !s1_vld_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   // Walk state.
   logic [31:0] col_acc_ff, col_acc_in;
   logic [31:0] row_acc_ff, row_acc_in;
   logic [10:0] col_cnt_ff, col_cnt_in;
   logic [9:0]  row_cnt_ff, row_cnt_in;
   logic        walk_active_ff, walk_active_in;

   stcb_pkg::action_type act;
   logic [10:0] span_rows_c, span_cols_c;
   logic [10:0] row_next;
   logic [11:0] col_next;
   logic        is_last, produces, keep;
   logic [31:0] step_ext, col_floor;

   assign act         = stcb_pkg::action_type'(req_action);
   assign span_rows_c = clamp_span(span_rows_ff);
   assign span_cols_c = clamp_span(span_cols_ff);
   assign row_next    = {1'b0, row_cnt_ff} + 11'd1;
   assign col_next    = {1'b0, col_cnt_ff} + 12'd1;
   assign step_ext    = {{6{col_step_ff[25]}}, col_step_ff};

   always_comb begin
      col_acc_in     = col_acc_ff;
      row_acc_in     = row_acc_ff;
      col_cnt_in     = col_cnt_ff;
      row_cnt_in     = row_cnt_ff;
      walk_active_in = walk_active_ff;
      is_last        = 1'b0;
      produces       = 1'b0;
      if (accept) begin
         case (act)
            stcb_pkg::ACT_START: begin
               produces       = 1'b1;
               col_acc_in     = {6'd0, col_start_ff};
               row_acc_in     = {6'd0, row_start_ff};
               col_cnt_in     = 11'd0;
               row_cnt_in     = 10'd0;
               walk_active_in = 1'b1;
            end
            stcb_pkg::ACT_PIXEL: begin
               if (walk_active_ff) begin
                  produces = 1'b1;
                  if (row_next >= span_rows_c) begin
                     row_cnt_in = 10'd0;
                     if (col_next >= {1'b0, span_cols_c}) begin
                        is_last        = 1'b1;
                        col_cnt_in     = 11'd0;
                        walk_active_in = 1'b0;
                     end else begin
                        col_cnt_in = col_next[10:0];
                        col_acc_in = col_acc_ff + step_ext;
                        row_acc_in = {6'd0, row_start_ff};
                     end
                  end else begin
                     row_cnt_in = row_next[9:0];
                     row_acc_in = row_acc_ff + {7'd0, row_step_ff};
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign keep      = accept && (produces || act == stcb_pkg::ACT_BL_LOAD);
   assign col_floor = 32'($signed(col_acc_in) >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_acc_ff     <= 32'd0;
         row_acc_ff     <= 32'd0;
         col_cnt_ff     <= 11'd0;
         row_cnt_ff     <= 10'd0;
         walk_active_ff <= 1'b0;
      end else begin
         col_acc_ff     <= col_acc_in;
         row_acc_ff     <= row_acc_in;
         col_cnt_ff     <= col_cnt_in;
         row_cnt_ff     <= row_cnt_in;
         walk_active_ff <= walk_active_in;
      end
   end

   // Stage 1: colormap data arrives, blend read issues, address multiply.
   stcb_pkg::action_type s1_act_ff;
   logic        s1_res_ff, s1_last_ff;
   logic [15:0] s1_tidx_ff;
   logic [7:0]  s1_tval_ff, s1_texel_ff, s1_bg_ff;
   logic [9:0]  s1_dcol_ff, s1_drow_ff;
   logic [19:0] s1_cf_ff, s1_rf_ff;

   logic [7:0]  cm_rd_data, bl_rd_data, s1_pix;
   logic [30:0] s1_prod_full;
   logic        bl_we;

   assign s1_vld_in = en1 ? keep : s1_vld_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_act_ff   <= act;
         s1_res_ff   <= produces;
         s1_last_ff  <= is_last;
         s1_tidx_ff  <= req_table_index;
         s1_tval_ff  <= req_table_value;
         s1_texel_ff <= req_texel;
         s1_bg_ff    <= req_background;
         s1_dcol_ff  <= col_cnt_ff[9:0];
         s1_drow_ff  <= row_cnt_ff;
         s1_cf_ff    <= col_floor[19:0];
         s1_rf_ff    <= 20'(row_acc_in >> FRAC_BITS);
      end
   end

   stcb_ram #(
      .WIDTH (8),
      .DEPTH (256)
   ) u_colormap (
      .clock   (clock),
      .wr_en   (accept && act == stcb_pkg::ACT_CM_LOAD),
      .wr_addr (req_table_index[7:0]),
      .wr_data (req_table_value),
      .rd_en   (en1),
      .rd_addr (req_texel),
      .rd_data (cm_rd_data)
   );

   assign s1_pix       = mode_ff[0] ? cm_rd_data : s1_texel_ff;
   assign s1_prod_full = s1_cf_ff * tex_height_ff;
   assign bl_we        = en2 && s1_vld_ff && s1_act_ff == stcb_pkg::ACT_BL_LOAD;

   stcb_ram #(
      .WIDTH (8),
      .DEPTH (65536)
   ) u_blend (
      .clock   (clock),
      .wr_en   (bl_we),
      .wr_addr (s1_tidx_ff),
      .wr_data (s1_tval_ff),
      .rd_en   (en2),
      .rd_addr ({s1_pix, s1_bg_ff}),
      .rd_data (bl_rd_data)
   );

   // Stage 2: blend data arrives, address add.
   stcb_pkg::action_type s2_act_ff;
   logic        s2_last_ff;
   logic [7:0]  s2_pix_ff;
   logic [9:0]  s2_dcol_ff, s2_drow_ff;
   logic [19:0] s2_prod_ff, s2_rf_ff;

   assign s2_vld_in = en2 ? (s1_vld_ff && s1_res_ff) : s2_vld_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_act_ff  <= s1_act_ff;
         s2_last_ff <= s1_last_ff;
         s2_pix_ff  <= s1_pix;
         s2_dcol_ff <= s1_dcol_ff;
         s2_drow_ff <= s1_drow_ff;
         s2_prod_ff <= s1_prod_full[19:0];
         s2_rf_ff   <= s1_rf_ff;
      end
   end

   // Output register.
   logic [7:0]  rsp_pix_ff;
   logic        rsp_pv_ff, rsp_fv_ff, rsp_last_ff;
   logic [9:0]  rsp_dcol_ff, rsp_drow_ff;
   logic [19:0] rsp_addr_ff, s2_addr;
   logic        s2_is_start;

   assign rsp_valid_in = out_load ? s2_vld_ff : rsp_valid_ff;
   assign s2_addr      = s2_prod_ff + s2_rf_ff;
   assign s2_is_start  = s2_act_ff == stcb_pkg::ACT_START;

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (s2_is_start) begin
            rsp_pix_ff  <= 8'd0;
            rsp_pv_ff   <= 1'b0;
            rsp_dcol_ff <= 10'd0;
            rsp_drow_ff <= 10'd0;
            rsp_addr_ff <= s2_addr;
            rsp_fv_ff   <= 1'b1;
            rsp_last_ff <= 1'b0;
         end else begin
            rsp_pix_ff  <= mode_ff[1] ? bl_rd_data : s2_pix_ff;
            rsp_pv_ff   <= 1'b1;
            rsp_dcol_ff <= s2_dcol_ff;
            rsp_drow_ff <= s2_drow_ff;
            rsp_addr_ff <= s2_last_ff ? 20'd0 : s2_addr;
            rsp_fv_ff   <= !s2_last_ff;
            rsp_last_ff <= s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_pixel     = rsp_pix_ff;
   assign rsp_pixel_valid   = rsp_pv_ff;
   assign rsp_dest_col      = rsp_dcol_ff;
   assign rsp_dest_row      = rsp_drow_ff;
   assign rsp_fetch_address = rsp_addr_ff;
   assign rsp_fetch_valid   = rsp_fv_ff;
   assign rsp_last          = rsp_last_ff;

   `STCB_ASSERT_SAME(a_last_no_fetch, rsp_valid && rsp_last, !rsp_fetch_valid && rsp_fetch_address == 20'd0)
   `STCB_ASSERT_NEXT(a_start_arms_walk, accept && act == stcb_pkg::ACT_START, walk_active_ff)
   `STCB_ASSERT_NEXT(a_idle_pixel_dropped, accept && act == stcb_pkg::ACT_PIXEL && !walk_active_ff, !(s1_vld_ff && s1_res_ff))
   `STCB_ASSERT_NEXT(a_stall_holds_stage2, rsp_valid_ff && rsp_stall && s2_vld_ff, s2_vld_ff && $stable(s2_prod_ff))

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the scaled texture column blitter with colormap and blend tables.
module tb;

   localparam int MAX_SPAN  = 1024;
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      stcb_pkg::action_type action;
      logic [15:0] table_index;
      logic [7:0]  table_value;
      logic [7:0]  texel;
      logic [7:0]  background;
   } blit_cmd_type;

   typedef struct packed {
      logic [7:0]  out_pixel;
      logic        pixel_valid;
      logic [9:0]  dest_col;
      logic [9:0]  dest_row;
      logic [19:0] fetch_address;
      logic        fetch_valid;
      logic        last;
   } blit_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [15:0] req_table_index;
   logic [7:0]  req_table_value;
   logic [7:0]  req_texel;
   logic [7:0]  req_background;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_pixel;
   logic        rsp_pixel_valid;
   logic [9:0]  rsp_dest_col;
   logic [9:0]  rsp_dest_row;
   logic [19:0] rsp_fetch_address;
   logic        rsp_fetch_valid;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   stcb_pkg::csr_index_type csr_index = stcb_pkg::CSR_COL_START;
   logic [25:0] csr_data = '0;

   blit_cmd_type drv_cmd = '0;
   blit_cmd_type blit_cmds[$];
   blit_rsp_type blit_results_due[$];
   int unsigned req_gap_pct = 31;
   int unsigned rsp_gap_pct = 73;
   int unsigned item_tally = 0;
   int unsigned mismatch_count = 0;

   // Register copies, shared by the predictor and the stimulus generator.
   logic [25:0] cfg_col_start  = '0;
   logic [25:0] cfg_row_start  = '0;
   logic [25:0] cfg_col_step   = stcb_pkg::COL_STEP_RESET;
   logic [24:0] cfg_row_step   = stcb_pkg::ROW_STEP_RESET;
   logic [10:0] cfg_span_cols  = 11'd1;
   logic [10:0] cfg_span_rows  = 11'd1;
   logic [10:0] cfg_tex_height = 11'd1;
   logic [1:0]  cfg_mode       = 2'd0;

   // Predictor state.
   logic [7:0]  colormap  [256];
   logic [7:0]  blend_lut [65536];
   logic [31:0] col_acc = '0;
   logic [31:0] row_acc = '0;
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;
   bit          walking = 1'b0;

   // Generator view of which table entries hold data.
   bit          cm_known    [256];
   logic [7:0]  cm_shadow   [256];
   bit          blend_known [65536];

   assign req_action      = drv_cmd.action;
   assign req_table_index = drv_cmd.table_index;
   assign req_table_value = drv_cmd.table_value;
   assign req_texel       = drv_cmd.texel;
   assign req_background  = drv_cmd.background;

   scaled_texture_column_blit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_table_index   (req_table_index),
      .req_table_value   (req_table_value),
      .req_texel         (req_texel),
      .req_background    (req_background),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_dest_col      (rsp_dest_col),
      .rsp_dest_row      (rsp_dest_row),
      .rsp_fetch_address (rsp_fetch_address),
      .rsp_fetch_valid   (rsp_fetch_valid),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   function automatic int unsigned span_limit(input logic [10:0] s);
      if (s == 11'd0) return 1;
      if (s > 11'(MAX_SPAN)) return MAX_SPAN;
      return int'(s);
   endfunction

   function automatic logic [19:0] texel_address();
      logic [31:0] col_whole;
      logic [31:0] row_whole;
      logic [31:0] sum;
      col_whole = 32'($signed(col_acc) >>> FRAC_BITS);
      row_whole = row_acc >> FRAC_BITS;
      sum = col_whole * {21'd0, cfg_tex_height} + row_whole;
      return sum[19:0];
   endfunction

   task automatic advance_blitter(input blit_cmd_type c);
      blit_rsp_type r;
      logic [7:0]  pix;
      int unsigned next_row;
      r = '0;
      case (c.action)
         stcb_pkg::ACT_CM_LOAD: colormap[c.table_index[7:0]] = c.table_value;
         stcb_pkg::ACT_BL_LOAD: blend_lut[c.table_index] = c.table_value;
         stcb_pkg::ACT_START: begin
            col_acc = 32'(cfg_col_start);
            row_acc = 32'(cfg_row_start);
            col_cnt = 0;
            row_cnt = 0;
            walking = 1'b1;
            r.fetch_address = texel_address();
            r.fetch_valid = 1'b1;
            blit_results_due.push_back(r);
         end
         stcb_pkg::ACT_PIXEL: begin
            if (walking) begin
               pix = c.texel;
               if (cfg_mode[0]) pix = colormap[pix];
               if (cfg_mode[1]) pix = blend_lut[{pix, c.background}];
               r.out_pixel = pix;
               r.pixel_valid = 1'b1;
               r.dest_col = col_cnt[9:0];
               r.dest_row = row_cnt[9:0];
               next_row = row_cnt + 1;
               if (next_row >= span_limit(cfg_span_rows)) begin
                  row_cnt = 0;
                  if (col_cnt + 1 >= span_limit(cfg_span_cols)) begin
                     r.last = 1'b1;
                     col_cnt = 0;
                     walking = 1'b0;
                  end else begin
                     col_cnt = col_cnt + 1;
                     col_acc = col_acc + {{6{cfg_col_step[25]}}, cfg_col_step};
                     row_acc = 32'(cfg_row_start);
                  end
               end else begin
                  row_cnt = next_row;
                  row_acc = row_acc + 32'(cfg_row_step);
               end
               if (!r.last) begin
                  r.fetch_address = texel_address();
                  r.fetch_valid = 1'b1;
               end
               blit_results_due.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      blit_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_stall === 1'b0) advance_blitter(drv_cmd);
         if (!req_valid || req_stall === 1'b0) begin
            if (blit_cmds.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               c = blit_cmds.pop_front();
               drv_cmd <= c;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      blit_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (blit_results_due.size() == 0) begin
            $display("%0t: result with no item waiting for it, expected none, %s",
                     $time, "actual");
            $display("   %0h %0h %0h %0h %0h", rsp_out_pixel, rsp_dest_col,
                     rsp_dest_row, rsp_fetch_address,
                     {rsp_pixel_valid, rsp_fetch_valid, rsp_last});
            mismatch_count++;
         end else begin
            want = blit_results_due.pop_front();
            check_field("out_pixel", 20'(want.out_pixel), 20'(rsp_out_pixel));
            check_field("pixel_valid", 20'(want.pixel_valid), 20'(rsp_pixel_valid));
            check_field("dest_col", 20'(want.dest_col), 20'(rsp_dest_col));
            check_field("dest_row", 20'(want.dest_row), 20'(rsp_dest_row));
            check_field("fetch_address", want.fetch_address, rsp_fetch_address);
            check_field("fetch_valid", 20'(want.fetch_valid), 20'(rsp_fetch_valid));
            check_field("last", 20'(want.last), 20'(rsp_last));
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
   end

   task automatic add_cmd(input stcb_pkg::action_type act, input logic [15:0] idx,
                          input logic [7:0] val, input logic [7:0] tx, input logic [7:0] bg);
      blit_cmd_type c;
      c.action = act;
      c.table_index = idx;
      c.table_value = val;
      c.texel = tx;
      c.background = bg;
      case (act)
         stcb_pkg::ACT_CM_LOAD: begin
            cm_known[idx[7:0]] = 1'b1;
            cm_shadow[idx[7:0]] = val;
         end
         stcb_pkg::ACT_BL_LOAD: blend_known[idx] = 1'b1;
         default: ;
      endcase
      blit_cmds.push_back(c);
      item_tally++;
   endtask

   task automatic add_start();
      add_cmd(stcb_pkg::ACT_START, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Table entries that a pixel will read are loaded first, so no unwritten entry is read.
   task automatic add_pixel(input logic [7:0] tx, input logic [7:0] bg);
      logic [7:0] pix;
      pix = tx;
      if (cfg_mode[0]) begin
         if (!cm_known[tx])
            add_cmd(stcb_pkg::ACT_CM_LOAD, {8'($urandom), tx}, 8'($urandom), 8'($urandom),
                    8'($urandom));
         pix = cm_shadow[tx];
      end
      if (cfg_mode[1] && !blend_known[{pix, bg}])
         add_cmd(stcb_pkg::ACT_BL_LOAD, {pix, bg}, 8'($urandom), 8'($urandom),
                 8'($urandom));
      add_cmd(stcb_pkg::ACT_PIXEL, 16'($urandom), 8'($urandom), tx, bg);
   endtask

   task automatic write_reg(input stcb_pkg::csr_index_type idx, input logic [25:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         stcb_pkg::CSR_COL_START:      cfg_col_start = data;
         stcb_pkg::CSR_ROW_START:      cfg_row_start = data;
         stcb_pkg::CSR_COL_STEP:       cfg_col_step = data;
         stcb_pkg::CSR_ROW_STEP:       cfg_row_step = data[24:0];
         stcb_pkg::CSR_SPAN_COLS:      cfg_span_cols = data[10:0];
         stcb_pkg::CSR_SPAN_ROWS:      cfg_span_rows = data[10:0];
         stcb_pkg::CSR_TEXTURE_HEIGHT: cfg_tex_height = data[10:0];
         stcb_pkg::CSR_MODE:           cfg_mode = data[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [25:0] c_start, input logic [25:0] r_start,
                               input logic [25:0] c_step, input logic [25:0] r_step,
                               input logic [10:0] cols, input logic [10:0] rows,
                               input logic [10:0] height, input logic [1:0] md);
      @(posedge clock);
      write_reg(stcb_pkg::CSR_COL_START, c_start);
      write_reg(stcb_pkg::CSR_ROW_START, r_start);
      write_reg(stcb_pkg::CSR_COL_STEP, c_step);
      write_reg(stcb_pkg::CSR_ROW_STEP, r_step);
      write_reg(stcb_pkg::CSR_SPAN_COLS, 26'(cols));
      write_reg(stcb_pkg::CSR_SPAN_ROWS, 26'(rows));
      write_reg(stcb_pkg::CSR_TEXTURE_HEIGHT, 26'(height));
      write_reg(stcb_pkg::CSR_MODE, 26'(md));
   endtask

   // The sender stays quiet until every predicted result has been seen.
   task automatic wait_idle();
      do @(negedge clock);
      while (blit_cmds.size() != 0 || req_valid || blit_results_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
                                              input int unsigned mid);
      case ($urandom_range(5))
         0: return lo;
         1: return hi;
         default: return mid;
      endcase
   endfunction

   task automatic random_phase();
      int unsigned walk_len;
      int unsigned npix;
      program_regs(26'(pick_value(0, 26'h3FF_FFFF, $urandom)),
                   26'(pick_value(0, 26'h3FF_FFFF, $urandom)),
                   26'(pick_value(26'h100_0000, 26'h300_0000,
                                  $urandom_range(1) ? $urandom
                                                    : $urandom_range(32'h6_0000) - 32'h3_0000)),
                   26'(pick_value(0, 26'h100_0000,
                                  $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h3_0000))),
                   11'(pick_value(0, 2047, $urandom_range(1, 6))),
                   11'(pick_value(0, MAX_SPAN, $urandom_range(1, 8))),
                   11'(pick_value(0, 2047, $urandom_range(1, 64))),
                   2'($urandom_range(3)));
      walk_len = span_limit(cfg_span_cols) * span_limit(cfg_span_rows);
      repeat ($urandom_range(2)) add_pixel(8'($urandom), 8'($urandom));
      repeat ($urandom_range(1, 3)) begin
         add_start();
         if (walk_len <= 64 && $urandom_range(99) < 80)
            npix = walk_len;
         else
            npix = $urandom_range(walk_len - 1 < 23 ? walk_len - 1 : 23);
         repeat (npix) begin
            if ($urandom_range(99) < 6)
               add_cmd($urandom_range(1) ? stcb_pkg::ACT_CM_LOAD : stcb_pkg::ACT_BL_LOAD,
                       16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            add_pixel(8'($urandom), 8'($urandom));
         end
      end
   endtask

   // The first 80 pixels of a walk under the widest span setting, either down a tall column or across a wide row.
   task automatic full_span_walk(input bit tall);
      if (tall)
         program_regs(26'($urandom), 26'($urandom), 26'($urandom),
                      26'($urandom_range(32'h3_0000)), 11'd0, 11'd2047, 11'(MAX_SPAN),
                      2'($urandom_range(3)));
      else
         program_regs(26'($urandom), 26'($urandom),
                      $urandom_range(1) ? 26'h100_0000 : 26'h300_0000, 26'($urandom),
                      11'(MAX_SPAN), 11'd1, 11'($urandom_range(1, 2047)),
                      2'($urandom_range(3)));
      add_start();
      repeat (80) add_pixel(8'($urandom), 8'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int unsigned phase_no;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_pixel(8'hA5, 8'h5A);
      add_start();
      add_pixel(8'hFF, 8'h00);
      add_cmd(stcb_pkg::ACT_CM_LOAD, 16'hFFFF, 8'($urandom), 8'h00, 8'hFF);
      add_cmd(stcb_pkg::ACT_CM_LOAD, 16'h0000, 8'($urandom), 8'hFF, 8'h00);
      add_cmd(stcb_pkg::ACT_BL_LOAD, 16'hFFFF, 8'($urandom), 8'h00, 8'h00);
      add_cmd(stcb_pkg::ACT_BL_LOAD, 16'h0000, 8'($urandom), 8'hFF, 8'hFF);
      wait_idle();

      program_regs(26'd0, 26'h3FF_FFFF, 26'h300_0000, 26'h1FF_FFFF, 11'd2, 11'd2,
                   11'd2047, 2'd3);
      add_start();
      add_pixel(8'hFF, 8'hFF);
      add_pixel(8'h00, 8'h00);
      add_start();
      add_pixel(8'hFF, 8'h00);
      add_pixel(8'h00, 8'hFF);
      add_pixel(8'hFF, 8'hFF);
      add_pixel(8'h00, 8'h00);
      add_pixel(8'h3C, 8'hC3);
      wait_idle();

      program_regs(26'h3FF_FFFF, 26'd0, 26'h200_0000, 26'h100_0000, 11'd0, 11'd0,
                   11'd0, 2'd1);
      add_start();
      add_pixel(8'hFF, 8'h00);
      wait_idle();

      item_tally = 0;
      phase_no = 0;
      while (item_tally < 850) begin
         phase_no++;
         if (item_tally < 283) begin
            req_gap_pct = 31;
            rsp_gap_pct = 73;
         end else if (item_tally < 567) begin
            req_gap_pct = 73;
            rsp_gap_pct = 31;
         end else begin
            req_gap_pct = 0;
            rsp_gap_pct = 0;
         end
         if (phase_no == 3 || phase_no == 9)
            full_span_walk(phase_no == 3);
         else
            random_phase();
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("scaled_texture_column_blit regression: pass");
      else
         $display("scaled_texture_column_blit regression: fail");
      $finish;
   end

   initial begin
      #1000000;
      $display("scaled_texture_column_blit regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/stcb_pkg.sv
sv/stcb_ram.sv
sv/scaled_texture_column_blit.sv
dv/tb.sv
